// ----- rtl/core/pfre_pkg.sv -----
// Shared types, codes and constants of the page framebuffer refresh engine.
// Used by the command queue, the front and back ends and the top level.
package pfre_pkg;

  localparam int MAX_FRAME_BYTES = 2048;
  localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);
  localparam int IDX_W           = 12;
  localparam int CMDQ_DEPTH      = 2;
  localparam int CMDQ_PTR_W      = $clog2(CMDQ_DEPTH);
  localparam int CFG_ADDR_W      = 4;
  localparam int CFG_DATA_W      = 32;

  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_FRAME_BYTES);

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  localparam logic [7:0] PAGE_CMD   = 8'hB0;
  localparam logic [7:0] HIGH_CMD   = 8'h10;
  localparam logic [7:0] BYTE_BLACK = 8'h00;
  localparam logic [7:0] BYTE_WHITE = 8'hFF;

  typedef enum logic [1:0] {
    OP_PIXEL,
    OP_FILL,
    OP_REFRESH,
    OP_TICK
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_RANGE,
    ST_BUSY,
    ST_IDLE
  } status_t;

  typedef enum logic [1:0] {
    CMD_RESULT,
    CMD_PIXEL,
    CMD_FILL,
    CMD_DATA
  } cmd_kind_t;

  typedef struct packed {
    status_t    status;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       is_data;
    logic       last_byte;
  } res_t;

  typedef struct packed {
    cmd_kind_t         kind;
    res_t              res;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        bit_sel;
    logic              color;
    logic              oob;
  } cmd_t;

  function automatic logic [2:0] size_log2(input logic [1:0] code);
    logic [2:0] lg;
    unique case (code)
      2'd0:    lg = 3'd5;
      2'd1:    lg = 3'd6;
      default: lg = 3'd7;
    endcase
    return lg;
  endfunction

endpackage

// ----- rtl/core/pfre_cmd_fifo.sv -----
// Short command queue between the front end and the back end.
// Depends on pfre_pkg for the command type and the queue depth.
module pfre_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  pfre_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           rd_en,
  output pfre_pkg::cmd_t rd_cmd,
  output logic           empty
);

  pfre_pkg::cmd_t                      q_r [pfre_pkg::CMDQ_DEPTH];
  logic [pfre_pkg::CMDQ_PTR_W-1:0]     wr_ptr_r;
  logic [pfre_pkg::CMDQ_PTR_W-1:0]     rd_ptr_r;
  logic [pfre_pkg::CMDQ_PTR_W:0]       count_r;
  logic [pfre_pkg::CMDQ_PTR_W-1:0]     wr_ptr_nxt;
  logic [pfre_pkg::CMDQ_PTR_W-1:0]     rd_ptr_nxt;

  localparam logic [pfre_pkg::CMDQ_PTR_W-1:0] PTR_LAST =
    pfre_pkg::CMDQ_PTR_W'(pfre_pkg::CMDQ_DEPTH - 1);
  localparam logic [pfre_pkg::CMDQ_PTR_W:0] COUNT_FULL =
    (pfre_pkg::CMDQ_PTR_W + 1)'(pfre_pkg::CMDQ_DEPTH);

  assign full   = (count_r == COUNT_FULL);
  assign empty  = (count_r == '0);
  assign rd_cmd = q_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/pfre_front.sv -----
// Front end: accepts requests, checks ranges, runs the refresh sequencer and
// turns each request into one queued command. Depends on pfre_pkg.
module pfre_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [1:0]     in_op,
  input  logic [6:0]     in_pos_x,
  input  logic [6:0]     in_pos_y,
  input  logic           in_color,
  input  logic [1:0]     width_code,
  input  logic [1:0]     height_code,
  input  logic [6:0]     column_offset,
  output pfre_pkg::cmd_t cmd,
  output logic           refreshing
);

  typedef enum logic [1:0] {
    PH_PAGE,
    PH_LOW,
    PH_HIGH,
    PH_DATA
  } phase_t;

  logic                       refreshing_r, refreshing_nxt;
  logic [3:0]                 page_r, page_nxt;
  phase_t                     phase_r, phase_nxt;
  logic [6:0]                 col_r, col_nxt;

  logic [2:0]                 lw;
  logic [2:0]                 lh;
  logic [7:0]                 width;
  logic [7:0]                 height;
  logic [4:0]                 pages;
  logic [3:0]                 fill_shift;
  logic [pfre_pkg::IDX_W-1:0] pix_idx;
  logic [pfre_pkg::IDX_W-1:0] data_idx;
  logic [pfre_pkg::IDX_W-1:0] fill_n;
  logic [pfre_pkg::IDX_W-1:0] fill_last;
  logic                       pix_bad;
  logic                       col_last;
  logic                       page_last;

  assign refreshing = refreshing_r;

  always_comb begin
    lw         = pfre_pkg::size_log2(width_code);
    lh         = pfre_pkg::size_log2(height_code);
    width      = 8'd1 << lw;
    height     = 8'd1 << lh;
    pages      = 5'(height >> 3);
    pix_idx    = pfre_pkg::IDX_W'(in_pos_x) + (pfre_pkg::IDX_W'(in_pos_y[6:3]) << lw);
    pix_bad    = ({1'b0, in_pos_x} >= width) || ({1'b0, in_pos_y} >= height) ||
                 (pix_idx >= pfre_pkg::MAX_IDX);
    fill_shift = 4'(lw) + 4'(lh) - 4'd3;
    fill_n     = pfre_pkg::IDX_W'(1) << fill_shift;
    fill_last  = ((fill_n > pfre_pkg::MAX_IDX) ? pfre_pkg::MAX_IDX : fill_n) - 1'b1;
    data_idx   = pfre_pkg::IDX_W'(col_r) + (pfre_pkg::IDX_W'(page_r) << lw);
    col_last   = ({1'b0, col_r} == (width - 8'd1));
    page_last  = ({1'b0, page_r} == (pages - 5'd1));

    refreshing_nxt = refreshing_r;
    page_nxt       = page_r;
    phase_nxt      = phase_r;
    col_nxt        = col_r;

    cmd                = '0;
    cmd.kind           = pfre_pkg::CMD_RESULT;
    cmd.res.status     = pfre_pkg::ST_OK;
    cmd.color          = in_color;

    if ((in_op != pfre_pkg::OP_TICK) && refreshing_r) begin
      cmd.res.status = pfre_pkg::ST_BUSY;
    end else begin
      unique case (pfre_pkg::op_t'(in_op))
        pfre_pkg::OP_PIXEL: begin
          if (pix_bad) begin
            cmd.res.status = pfre_pkg::ST_RANGE;
          end else begin
            cmd.kind    = pfre_pkg::CMD_PIXEL;
            cmd.addr    = pix_idx[pfre_pkg::ADDR_W-1:0];
            cmd.bit_sel = in_pos_y[2:0];
          end
        end
        pfre_pkg::OP_FILL: begin
          cmd.kind = pfre_pkg::CMD_FILL;
          cmd.addr = fill_last[pfre_pkg::ADDR_W-1:0];
        end
        pfre_pkg::OP_REFRESH: begin
          refreshing_nxt = 1'b1;
          page_nxt       = '0;
          phase_nxt      = PH_PAGE;
          col_nxt        = '0;
        end
        default: begin
          if (!refreshing_r) begin
            cmd.res.status = pfre_pkg::ST_IDLE;
          end else begin
            cmd.res.byte_valid = 1'b1;
            unique case (phase_r)
              PH_PAGE: begin
                cmd.res.out_byte = pfre_pkg::PAGE_CMD + {4'b0, page_r};
                phase_nxt        = PH_LOW;
              end
              PH_LOW: begin
                cmd.res.out_byte = {4'b0, column_offset[3:0]};
                phase_nxt        = PH_HIGH;
              end
              PH_HIGH: begin
                cmd.res.out_byte = pfre_pkg::HIGH_CMD | {5'b0, column_offset[6:4]};
                phase_nxt        = PH_DATA;
                col_nxt          = '0;
              end
              default: begin
                cmd.kind        = pfre_pkg::CMD_DATA;
                cmd.res.is_data = 1'b1;
                cmd.addr        = data_idx[pfre_pkg::ADDR_W-1:0];
                cmd.oob         = (data_idx >= pfre_pkg::MAX_IDX);
                if (col_last) begin
                  col_nxt   = '0;
                  phase_nxt = PH_PAGE;
                  if (page_last) begin
                    cmd.res.last_byte = 1'b1;
                    refreshing_nxt    = 1'b0;
                    page_nxt          = '0;
                  end else begin
                    page_nxt = page_r + 4'd1;
                  end
                end else begin
                  col_nxt = col_r + 7'd1;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refreshing_r <= 1'b0;
      page_r       <= '0;
      phase_r      <= PH_PAGE;
      col_r        <= '0;
    end else if (accept) begin
      refreshing_r <= refreshing_nxt;
      page_r       <= page_nxt;
      phase_r      <= phase_nxt;
      col_r        <= col_nxt;
    end
  end

endmodule

// ----- rtl/core/pfre_back.sv -----
// Back end: owns the frame memory, carries out pixel updates, fills and data
// reads, and holds the result register. Depends on pfre_pkg.
module pfre_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  pfre_pkg::cmd_t q_cmd,
  output logic           q_pop,
  input  logic           out_pop,
  output logic           out_valid,
  output pfre_pkg::res_t out_res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MOD,
    S_FILL,
    S_EMIT
  } state_t;

  state_t                      state_r;
  pfre_pkg::cmd_t              cmd_r;
  logic [pfre_pkg::ADDR_W-1:0] fill_cnt_r;
  logic                        out_valid_r;
  pfre_pkg::res_t              out_res_r;

  logic [7:0]                  mem [pfre_pkg::MAX_FRAME_BYTES];
  logic [7:0]                  rd_data_r;
  logic                        mem_re;
  logic                        mem_we;
  logic [pfre_pkg::ADDR_W-1:0] mem_waddr;
  logic [7:0]                  mem_wdata;
  logic [7:0]                  bit_mask;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    bit_mask  = 8'd1 << cmd_r.bit_sel;
    mem_re    = (state_r == S_RD);
    mem_we    = 1'b0;
    mem_waddr = cmd_r.addr;
    mem_wdata = cmd_r.color ? (rd_data_r | bit_mask) : (rd_data_r & ~bit_mask);
    if ((state_r == S_MOD) && (cmd_r.kind == pfre_pkg::CMD_PIXEL)) begin
      mem_we = 1'b1;
    end else if (state_r == S_FILL) begin
      mem_we    = 1'b1;
      mem_waddr = fill_cnt_r;
      mem_wdata = cmd_r.color ? pfre_pkg::BYTE_WHITE : pfre_pkg::BYTE_BLACK;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[cmd_r.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_EMIT) && (!out_valid_r || out_pop)) begin
        out_valid_r <= 1'b1;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r      <= q_cmd;
            fill_cnt_r <= '0;
            unique case (q_cmd.kind)
              pfre_pkg::CMD_PIXEL: state_r <= S_RD;
              pfre_pkg::CMD_DATA:  state_r <= S_RD;
              pfre_pkg::CMD_FILL:  state_r <= S_FILL;
              default:             state_r <= S_EMIT;
            endcase
          end
        end
        S_RD: begin
          state_r <= S_MOD;
        end
        S_MOD: begin
          if (cmd_r.kind == pfre_pkg::CMD_DATA) begin
            cmd_r.res.out_byte <= cmd_r.oob ? pfre_pkg::BYTE_BLACK : rd_data_r;
          end
          state_r <= S_EMIT;
        end
        S_FILL: begin
          if (fill_cnt_r == cmd_r.addr) begin
            state_r <= S_EMIT;
          end else begin
            fill_cnt_r <= fill_cnt_r + 1'b1;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_pop) begin
            out_res_r <= cmd_r.res;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/page_framebuffer_refresh_engine_top.sv -----
// Top level of the page framebuffer refresh engine: register port, front end,
// command queue and back end. Depends on pfre_pkg, pfre_front, pfre_cmd_fifo, pfre_back.
//
//  Channel   Handshake               Payload
//  -------   ---------------------   -----------------------------------------------
//  input     push / full             in_op, in_pos_x, in_pos_y, in_color
//  result    pop / empty             out_status, out_byte_valid, out_out_byte, ...
//  config    psel, penable, pwrite   paddr, pwdata, prdata (pready tied high)
//
// The front end takes one request per cycle while the two-entry command queue has room.
// The back end sets the pace: a result-only command goes straight to its result, a pixel
// write or a refresh data byte takes a memory read, a modify and its result, and a fill
// of N bytes takes one memory write per cycle, then its result. The result register lets
// the back end take the next command while a result waits. Reset clears control state
// only; the frame memory holds garbage until filled or written.
module page_framebuffer_refresh_engine_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      in_op,
  input  logic [6:0]                      in_pos_x,
  input  logic [6:0]                      in_pos_y,
  input  logic                            in_color,
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      out_status,
  output logic                            out_byte_valid,
  output logic [7:0]                      out_out_byte,
  output logic                            out_is_data,
  output logic                            out_last_byte,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pfre_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pfre_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pfre_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  logic [1:0]     width_code_r;
  logic [1:0]     height_code_r;
  logic [6:0]     column_offset_r;
  logic           cfg_we;
  logic [1:0]     cfg_idx;
  logic           refreshing;
  logic           q_push;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  pfre_pkg::cmd_t front_cmd;
  pfre_pkg::cmd_t head_cmd;
  logic           res_valid;
  pfre_pkg::res_t res;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    case (cfg_idx)
      pfre_pkg::REG_WIDTH:  prdata = pfre_pkg::CFG_DATA_W'(width_code_r);
      pfre_pkg::REG_HEIGHT: prdata = pfre_pkg::CFG_DATA_W'(height_code_r);
      pfre_pkg::REG_OFFSET: prdata = pfre_pkg::CFG_DATA_W'(column_offset_r);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_code_r    <= 2'd2;
      height_code_r   <= 2'd1;
      column_offset_r <= '0;
    end else if (cfg_we && !refreshing) begin
      unique case (cfg_idx)
        pfre_pkg::REG_WIDTH:  width_code_r    <= pwdata[1:0];
        pfre_pkg::REG_HEIGHT: height_code_r   <= pwdata[1:0];
        pfre_pkg::REG_OFFSET: column_offset_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  assign full   = q_full;
  assign q_push = push && !q_full;

  pfre_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (q_push),
    .in_op         (in_op),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_color      (in_color),
    .width_code    (width_code_r),
    .height_code   (height_code_r),
    .column_offset (column_offset_r),
    .cmd           (front_cmd),
    .refreshing    (refreshing)
  );

  pfre_cmd_fifo u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_cmd (front_cmd),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_cmd (head_cmd),
    .empty  (q_empty)
  );

  pfre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_pop   (pop),
    .out_valid (res_valid),
    .out_res   (res)
  );

  assign empty          = !res_valid;
  assign out_status     = res.status;
  assign out_byte_valid = res.byte_valid;
  assign out_out_byte   = res.out_byte;
  assign out_is_data    = res.is_data;
  assign out_last_byte  = res.last_byte;

  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && refreshing) |=>
      ($stable(width_code_r) && $stable(height_code_r) && $stable(column_offset_r)))
    else $error("Register changed during a refresh.");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("Command queue written while full.");

  a_quiet_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_byte_valid) |->
      ((out_out_byte == 8'h00) && !out_is_data && !out_last_byte))
    else $error("Byte fields set on a result without a stream byte.");

  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last_byte) |-> (out_is_data && out_byte_valid))
    else $error("Final refresh byte is not a data byte.");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for page_framebuffer_refresh_engine_top: directed and random draw,
// fill and refresh transactions checked against a predictor of the frame store and stream.
// Depends on pfre_pkg and the RTL of the engine.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pfre_pkg::op_t op;
    logic [6:0]    x;
    logic [6:0]    y;
    logic          color;
  } draw_req_t;

  typedef enum logic [1:0] {
    SEQ_PAGE,
    SEQ_LOW,
    SEQ_HIGH,
    SEQ_DATA
  } scan_step_t;

  typedef enum int {
    PACE_TX_SLOW,
    PACE_RX_SLOW,
    PACE_FREE
  } pace_t;

  localparam logic [1:0] REG_NONE = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            push = 1'b0;
  logic                            full;
  logic [1:0]                      in_op = '0;
  logic [6:0]                      in_pos_x = '0;
  logic [6:0]                      in_pos_y = '0;
  logic                            in_color = 1'b0;
  logic                            empty;
  logic                            pop = 1'b0;
  logic [1:0]                      out_status;
  logic                            out_byte_valid;
  logic [7:0]                      out_out_byte;
  logic                            out_is_data;
  logic                            out_last_byte;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [pfre_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [pfre_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [pfre_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  draw_req_t       pending_reqs[$];
  pfre_pkg::res_t  expected_results[$];
  draw_req_t       offered_req;
  int              accepted_count = 0;
  int              mismatch_count = 0;
  pace_t           pace_mode = PACE_TX_SLOW;
  logic            rx_blocked = 1'b0;

  logic [7:0] frame_shadow [pfre_pkg::MAX_FRAME_BYTES];
  logic       scan_active = 1'b0;
  logic [3:0] scan_page = '0;
  scan_step_t scan_step = SEQ_PAGE;
  logic [6:0] scan_col = '0;
  logic [1:0] wcode = 2'd2;
  logic [1:0] hcode = 2'd1;
  logic [6:0] col_offset = '0;

  page_framebuffer_refresh_engine_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_op          (in_op),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_color       (in_color),
    .empty          (empty),
    .pop            (pop),
    .out_status     (out_status),
    .out_byte_valid (out_byte_valid),
    .out_out_byte   (out_out_byte),
    .out_is_data    (out_is_data),
    .out_last_byte  (out_last_byte),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk = ~clk;

  function automatic int panel_dim(input logic [1:0] code);
    case (code)
      2'd0:    return 32;
      2'd1:    return 64;
      default: return 128;
    endcase
  endfunction

  function automatic pfre_pkg::res_t render_step(input draw_req_t req);
    pfre_pkg::res_t r;
    int   w;
    int   h;
    int   idx;
    int   n;
    int   i;
    r = '0;
    r.status = pfre_pkg::ST_OK;
    w = panel_dim(wcode);
    h = panel_dim(hcode);
    if (req.op != pfre_pkg::OP_TICK && scan_active) begin
      r.status = pfre_pkg::ST_BUSY;
    end else begin
      case (req.op)
        pfre_pkg::OP_PIXEL: begin
          idx = int'(req.x) + int'(req.y >> 3) * w;
          if (int'(req.x) >= w || int'(req.y) >= h || idx >= pfre_pkg::MAX_FRAME_BYTES) begin
            r.status = pfre_pkg::ST_RANGE;
          end else begin
            frame_shadow[idx][req.y[2:0]] = req.color;
          end
        end
        pfre_pkg::OP_FILL: begin
          n = w * h / 8;
          if (n > pfre_pkg::MAX_FRAME_BYTES) n = pfre_pkg::MAX_FRAME_BYTES;
          for (i = 0; i < n; i++) begin
            frame_shadow[i] = req.color ? pfre_pkg::BYTE_WHITE : pfre_pkg::BYTE_BLACK;
          end
        end
        pfre_pkg::OP_REFRESH: begin
          scan_active = 1'b1;
          scan_page = '0;
          scan_step = SEQ_PAGE;
          scan_col = '0;
        end
        default: begin
          if (!scan_active) begin
            r.status = pfre_pkg::ST_IDLE;
          end else begin
            r.byte_valid = 1'b1;
            case (scan_step)
              SEQ_PAGE: begin
                r.out_byte = pfre_pkg::PAGE_CMD + {4'h0, scan_page};
                scan_step = SEQ_LOW;
              end
              SEQ_LOW: begin
                r.out_byte = {4'h0, col_offset[3:0]};
                scan_step = SEQ_HIGH;
              end
              SEQ_HIGH: begin
                r.out_byte = pfre_pkg::HIGH_CMD | {5'h0, col_offset[6:4]};
                scan_step = SEQ_DATA;
                scan_col = '0;
              end
              default: begin
                r.is_data = 1'b1;
                idx = int'(scan_col) + int'(scan_page) * w;
                r.out_byte = (idx < pfre_pkg::MAX_FRAME_BYTES) ? frame_shadow[idx] : 8'h00;
                if (int'(scan_col) + 1 >= w) begin
                  scan_col = '0;
                  scan_step = SEQ_PAGE;
                  if (int'(scan_page) + 1 >= h / 8) begin
                    r.last_byte = 1'b1;
                    scan_active = 1'b0;
                    scan_page = '0;
                  end else begin
                    scan_page = scan_page + 4'd1;
                  end
                end else begin
                  scan_col = scan_col + 7'd1;
                end
              end
            endcase
          end
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin : request_driver
    int idle_pct;
    idle_pct = (pace_mode == PACE_TX_SLOW) ? 25 : (pace_mode == PACE_RX_SLOW) ? 50 : 0;
    if (push && !full) begin
      expected_results.push_back(render_step(offered_req));
      accepted_count++;
    end
    if (!(push && full)) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        offered_req = pending_reqs.pop_front();
        push     <= 1'b1;
        in_op    <= offered_req.op;
        in_pos_x <= offered_req.x;
        in_pos_y <= offered_req.y;
        in_color <= offered_req.color;
      end else begin
        push <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    pfre_pkg::res_t want;
    int   idle_pct;
    idle_pct = (pace_mode == PACE_TX_SLOW) ? 50 : (pace_mode == PACE_RX_SLOW) ? 25 : 0;
    if (rst_n && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no expectation waiting");
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 8'(want.status), 8'(out_status));
        check_field("byte_valid", 8'(want.byte_valid), 8'(out_byte_valid));
        check_field("out_byte", want.out_byte, out_out_byte);
        check_field("is_data", 8'(want.is_data), 8'(out_is_data));
        check_field("last_byte", 8'(want.last_byte), 8'(out_last_byte));
      end
    end
    pop <= !rx_blocked && ($urandom_range(0, 99) >= idle_pct);
  end

  task automatic add_req(input pfre_pkg::op_t op, input int x, input int y, input logic color);
    draw_req_t req;
    req.op = op;
    req.x = 7'(x);
    req.y = 7'(y);
    req.color = color;
    pending_reqs.push_back(req);
  endtask

  task automatic add_noise_req(input pfre_pkg::op_t op);
    add_req(op, $urandom_range(0, 127), $urandom_range(0, 127), 1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || push || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] reg_idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (!scan_active) begin
      case (reg_idx)
        pfre_pkg::REG_WIDTH:  wcode = value[1:0];
        pfre_pkg::REG_HEIGHT: hcode = value[1:0];
        pfre_pkg::REG_OFFSET: col_offset = value[6:0];
        default:              ;
      endcase
    end
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [1:0] wc, input logic [1:0] hc, input logic [6:0] off,
                           input int budget, input pace_t mode);
    int   w;
    int   h;
    int   issued;
    int   pick;
    int   t;
    logic paused;
    drain();
    pace_mode = mode;
    cfg_write(pfre_pkg::REG_WIDTH, 32'(wc));
    cfg_write(pfre_pkg::REG_HEIGHT, 32'(hc));
    cfg_write(pfre_pkg::REG_OFFSET, 32'(off));
    w = panel_dim(wc);
    h = panel_dim(hc);
    issued = 0;
    paused = 1'b0;
    while (issued < budget) begin
      if (!paused && issued >= budget / 2) begin
        drain();
        paused = 1'b1;
      end
      pick = (issued == 0) ? 9 : $urandom_range(0, 9);
      if (pick <= 4) begin
        if ($urandom_range(0, 4) != 0) begin
          add_req(pfre_pkg::OP_PIXEL, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                  1'($urandom_range(0, 1)));
        end else begin
          add_noise_req(pfre_pkg::OP_PIXEL);
        end
        issued++;
      end else if (pick == 5) begin
        add_noise_req(pfre_pkg::OP_FILL);
        issued++;
      end else if (pick == 6) begin
        add_noise_req(pfre_pkg::OP_TICK);
        issued++;
      end else begin
        add_noise_req(pfre_pkg::OP_REFRESH);
        issued++;
        for (t = 0; t < (h / 8) * (3 + w); t++) begin
          if ($urandom_range(0, 99) < 8) begin
            add_noise_req(pfre_pkg::op_t'($urandom_range(0, 2)));
            issued++;
          end
          add_noise_req(pfre_pkg::OP_TICK);
          issued++;
        end
        if ($urandom_range(0, 1) != 0) begin
          add_noise_req(pfre_pkg::OP_TICK);
          issued++;
        end
      end
    end
  endtask

  initial begin : long_backpressure
    wait (accepted_count >= 700);
    @(negedge clk);
    rx_blocked = 1'b1;
    repeat (300) @(negedge clk);
    rx_blocked = 1'b0;
  end

  initial begin : run_limit
    #800us;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int t;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    cfg_write(pfre_pkg::REG_WIDTH, 32'd2);
    cfg_write(pfre_pkg::REG_HEIGHT, 32'd2);
    cfg_write(pfre_pkg::REG_OFFSET, 32'd0);
    add_req(pfre_pkg::OP_FILL, 0, 0, 1'b1);
    add_req(pfre_pkg::OP_PIXEL, 0, 0, 1'b0);
    add_req(pfre_pkg::OP_PIXEL, 127, 127, 1'b0);
    add_req(pfre_pkg::OP_PIXEL, 127, 0, 1'b0);
    add_req(pfre_pkg::OP_PIXEL, 0, 127, 1'b1);
    add_req(pfre_pkg::OP_TICK, 127, 127, 1'b1);

    drain();
    cfg_write(pfre_pkg::REG_WIDTH, 32'd3);
    cfg_write(pfre_pkg::REG_HEIGHT, 32'd3);
    cfg_write(pfre_pkg::REG_OFFSET, 32'd127);
    add_req(pfre_pkg::OP_PIXEL, 127, 127, 1'b1);
    add_req(pfre_pkg::OP_FILL, 0, 0, 1'b0);
    add_req(pfre_pkg::OP_PIXEL, 64, 100, 1'b1);

    drain();
    cfg_write(pfre_pkg::REG_WIDTH, 32'd0);
    cfg_write(pfre_pkg::REG_HEIGHT, 32'd0);
    cfg_write(pfre_pkg::REG_OFFSET, 32'd90);
    add_req(pfre_pkg::OP_PIXEL, 32, 0, 1'b1);
    add_req(pfre_pkg::OP_PIXEL, 0, 32, 1'b1);
    add_req(pfre_pkg::OP_FILL, 0, 0, 1'b1);
    add_req(pfre_pkg::OP_PIXEL, 31, 31, 1'b0);
    add_req(pfre_pkg::OP_REFRESH, 0, 0, 1'b0);
    add_req(pfre_pkg::OP_PIXEL, 1, 1, 1'b1);
    add_req(pfre_pkg::OP_FILL, 0, 0, 1'b0);
    add_req(pfre_pkg::OP_REFRESH, 0, 0, 1'b0);
    for (t = 0; t < 5; t++) add_req(pfre_pkg::OP_TICK, 0, 0, 1'b0);

    // Register writes in the middle of a refresh must leave the stream untouched.
    drain();
    cfg_write(pfre_pkg::REG_WIDTH, 32'd1);
    cfg_write(REG_NONE, 32'hFFFF_FFFF);
    for (t = 5; t < 141; t++) add_req(pfre_pkg::OP_TICK, 0, 0, 1'b0);

    run_phase(2'd0, 2'd0, 7'($urandom_range(0, 127)), 150, PACE_TX_SLOW);
    run_phase(2'd1, 2'd0, 7'd127, 200, PACE_RX_SLOW);
    run_phase(2'd0, 2'd3, 7'($urandom_range(0, 127)), 600, PACE_FREE);

    drain();
    repeat (50) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/pfre_pkg.sv
rtl/core/pfre_cmd_fifo.sv
rtl/core/pfre_front.sv
rtl/core/pfre_back.sv
rtl/core/page_framebuffer_refresh_engine_top.sv
sim/testbench.sv
